>>> hdl/posl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the positional byte list.
// No dependencies; every other file of the block refers to this package.
package posl_pkg;

    localparam int POS_W  = 7;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    // Comparison width: one bit above the position so count + 1 never wraps
    localparam int CMP_W  = POS_W + 1;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  idx;
        logic [BYTE_W-1:0] item;
    } posl_cmd_t;

endpackage

>>> hdl/posl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the list.
// Depends on posl_pkg for field widths.
interface posl_req_if;
    logic                        valid;
    logic                        ready;
    logic [posl_pkg::KIND_W-1:0] kind;
    logic [posl_pkg::POS_W-1:0]  position;
    logic [posl_pkg::BYTE_W-1:0] item;

    modport source (output valid, output kind, output position, output item, input ready);
    modport sink   (input valid, input kind, input position, input item, output ready);
endinterface

interface posl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [posl_pkg::STAT_W-1:0] status;
    logic [posl_pkg::BYTE_W-1:0] data;

    modport source (output valid, output status, output data, input ready);
    modport sink   (input valid, input status, input data, output ready);
endinterface

>>> hdl/posl_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list: holds a byte, takes the new byte or its
// left neighbor's byte on insert and its right neighbor's on delete. Depends on posl_pkg.
module posl_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        clk,
    input  posl_pkg::posl_cmd_t         cmd,
    input  logic [posl_pkg::BYTE_W-1:0] left_val,
    input  logic [posl_pkg::BYTE_W-1:0] right_val,
    output logic [posl_pkg::BYTE_W-1:0] val,
    output logic [posl_pkg::BYTE_W-1:0] rd_val
);

    localparam logic [posl_pkg::POS_W-1:0] MY_IDX = posl_pkg::POS_W'(CELL_IDX);

    logic [posl_pkg::BYTE_W-1:0] val_reg;
    logic [posl_pkg::BYTE_W-1:0] val_next;

    // Select next byte: write at the target, shift up above it on insert,
    // pull from the right at and above it on delete
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins)
        begin
            if (cmd.idx == MY_IDX)
                val_next = cmd.item;
            else if (cmd.idx < MY_IDX)
                val_next = left_val;
        end
        else if (cmd.del && (cmd.idx <= MY_IDX))
        begin
            val_next = right_val;
        end
    end

    // Hold the byte
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val    = val_reg;
    // Drive the byte onto the read bus only when this cell is addressed
    assign rd_val = (cmd.idx == MY_IDX) ? val_reg : '0;

endmodule

>>> hdl/posl_chain.sv
`timescale 1ns / 1ps
// Row of LIST_DEPTH cells linked to their neighbors, plus the read bus.
// Depends on posl_pkg and posl_cell.
module posl_chain #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                        clk,
    input  posl_pkg::posl_cmd_t         cmd,
    output logic [posl_pkg::BYTE_W-1:0] rd_data
);

    logic [posl_pkg::BYTE_W-1:0] cell_val [LIST_DEPTH];
    logic [posl_pkg::BYTE_W-1:0] cell_rd  [LIST_DEPTH];

    // Build the chain; the ends see zero from outside
    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [posl_pkg::BYTE_W-1:0] left_in;
        logic [posl_pkg::BYTE_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_val[g-1];
        end

        if (g == LIST_DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_val[g+1];
        end

        posl_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .left_val  (left_in),
            .right_val (right_in),
            .val       (cell_val[g]),
            .rd_val    (cell_rd[g])
        );
    end

    // Merge the one-hot read outputs
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
            rd_data = rd_data | cell_rd[i];
    end

endmodule

>>> hdl/positional_char_list_unit.sv
`timescale 1ns / 1ps
// Positional byte list: ordered sequence of up to LIST_DEPTH bytes.
// Depends on posl_pkg, posl_if (posl_req_if, posl_rsp_if) and posl_chain.
//
// Usage:
//   req carries one request per transaction: kind (insert, delete, read),
//   a 1-based position and, for insert, the byte. rsp returns exactly one
//   transaction per request: status (ok, invalid position, list full) and
//   the byte removed or read, zero otherwise.
//   Each request is decoded, checked against the element count and applied
//   to the whole row of cells in the cycle it is accepted; every cell
//   shifts in parallel with its neighbor, so the result is registered at
//   acceptance and valid in the next cycle, and one request can be taken
//   every cycle while rsp takes each result.
//   The result register is the only buffer: while rsp is stalled with a
//   result waiting, req.ready stays low; it rises in the cycle the waiting
//   result is taken, so no cycle is lost.
//   Reset clears the element count and the result valid flag; cell contents
//   are left as they are and are never read before being written.
module positional_char_list_unit #(
    parameter int LIST_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    posl_req_if.sink          req,
    posl_rsp_if.source        rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [posl_pkg::STAT_W-1:0]  status_reg;
    logic [posl_pkg::STAT_W-1:0]  status_next;
    logic [posl_pkg::BYTE_W-1:0]  data_reg;
    logic [posl_pkg::BYTE_W-1:0]  data_next;

    logic                         accept;
    logic [posl_pkg::CMP_W-1:0]   pos_ext;
    logic [posl_pkg::CMP_W-1:0]   cnt_ext;
    logic                         pos_nz;
    logic                         ins_pos_ok;
    logic                         acc_pos_ok;
    logic                         is_full;
    logic [posl_pkg::BYTE_W-1:0]  rd_data;
    posl_pkg::posl_cmd_t          cmd;
    logic [posl_pkg::STAT_W-1:0]  st_calc;
    logic                         do_ins;
    logic                         do_del;
    logic                         do_rd;

    // Accept when the result register is free or being emptied
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Check the position against the current count
    assign pos_ext    = posl_pkg::CMP_W'(req.position);
    assign cnt_ext    = posl_pkg::CMP_W'(count_reg);
    assign pos_nz     = (req.position != '0);
    assign ins_pos_ok = pos_nz && (pos_ext <= (cnt_ext + 1'b1));
    assign acc_pos_ok = pos_nz && (pos_ext <= cnt_ext);
    assign is_full    = (count_reg >= CNT_FULL);

    // Decode the request into a status and the cell operation
    always_comb
    begin
        st_calc = posl_pkg::ST_BADPOS;
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_rd   = 1'b0;
        case (req.kind)
            posl_pkg::KIND_INSERT:
            begin
                if (!ins_pos_ok)
                    st_calc = posl_pkg::ST_BADPOS;
                else if (is_full)
                    st_calc = posl_pkg::ST_FULL;
                else
                begin
                    st_calc = posl_pkg::ST_OK;
                    do_ins  = 1'b1;
                end
            end
            posl_pkg::KIND_DELETE:
            begin
                if (acc_pos_ok)
                begin
                    st_calc = posl_pkg::ST_OK;
                    do_del  = 1'b1;
                    do_rd   = 1'b1;
                end
            end
            posl_pkg::KIND_READ:
            begin
                if (acc_pos_ok)
                begin
                    st_calc = posl_pkg::ST_OK;
                    do_rd   = 1'b1;
                end
            end
            default:
            begin
                st_calc = posl_pkg::ST_BADPOS;
            end
        endcase
    end

    // Broadcast the command to the chain
    always_comb
    begin
        cmd.ins  = accept && do_ins;
        cmd.del  = accept && do_del;
        cmd.idx  = req.position - 1'b1;
        cmd.item = req.item;
    end

    posl_chain #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    // Next count, result and valid flag
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = st_calc;
            data_next      = do_rd ? rd_data : '0;
            if (do_ins)
                count_next = count_reg + 1'b1;
            else if (do_del)
                count_next = count_reg - 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.data   = data_reg;

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("element count above capacity");

    // Successful insert grows the list by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("insert did not increment count");

    // Successful delete shrinks the list by one
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("delete did not decrement count");

    // Failed requests return zero data
    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != posl_pkg::ST_OK)) |-> (data_reg == '0))
        else $error("nonzero data on failed request");

    // A full status is reported only with a full list
    a_full_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == posl_pkg::ST_FULL)) |-> (count_reg == CNT_FULL))
        else $error("full status with list not full");

endmodule
